[rtl/pwli_pkg.sv]
// ----------------------------------------------------------------------------
// pwli_pkg - shared types and constants of the piecewise linear interpolator
// words of both channels, breakpoint and search token layout, status codes
// ----------------------------------------------------------------------------
package pwli_pkg;

  localparam int CFG_W = 5;
  localparam int DIV_CYCLES = 32;
  localparam int CNT_W = $clog2(DIV_CYCLES);

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              action;
    logic [3:0]        point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } pwli_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]        status;
  } pwli_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pwli_point_t;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic              pend;
    logic signed [31:0] x0;
    pwli_point_t       lo;
    pwli_point_t       hi;
  } pwli_token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CALC
  } pwli_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_FIN,
    PH_DONE
  } pwli_phase_t;

endpackage

[rtl/pwli_cell.sv]
// ----------------------------------------------------------------------------
// pwli_cell - one breakpoint slot of the search chain
// holds one (x, y) pair and passes the segment search token to the next cell
// ----------------------------------------------------------------------------
module pwli_cell #(
  parameter int MAX_POINTS = 16,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [3:0]                   wr_slot,
  input  pwli_pkg::pwli_point_t        wr_point,
  input  logic [$clog2(MAX_POINTS+1)-1:0] num_points,
  input  pwli_pkg::pwli_point_t        prev_point,
  input  pwli_pkg::pwli_token_t        tok_in,
  output pwli_pkg::pwli_point_t        point,
  output pwli_pkg::pwli_token_t        tok_out
);
  import pwli_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic FIRST = (IDX == 0);

  logic        gt;
  logic        last;
  pwli_token_t tok_next;

  assign gt   = point.x > tok_in.x0;
  assign last = (num_points == CW'(IDX + 1));

  always_comb begin
    tok_next = tok_in;
    tok_next.pend = FIRST ? gt : 1'b0;
    tok_next.done = tok_in.done || (!FIRST && (gt || tok_in.pend || last));
    if (!tok_in.done && !FIRST) begin
      tok_next.lo = prev_point;
      tok_next.hi = point;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) == 32'(IDX))) begin
      point <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.done <= tok_next.done;
    tok_out.pend <= tok_next.pend;
    tok_out.x0   <= tok_next.x0;
    tok_out.lo   <= tok_next.lo;
    tok_out.hi   <= tok_next.hi;
  end

endmodule

[rtl/pwli_arith.sv]
// ----------------------------------------------------------------------------
// pwli_arith - slope arithmetic of one query
// one 32x32 multiply, a restoring divide at two quotient bits per cycle,
// then offset, saturation and status
// ----------------------------------------------------------------------------
module pwli_arith (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pwli_pkg::pwli_token_t seg,
  input  logic                  take,
  output logic                  res_valid,
  output pwli_pkg::pwli_out_t   res
);
  import pwli_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = v[32] ? 33'(-v) : 33'(v);
    return n[31:0];
  endfunction

  pwli_phase_t       phase, phase_next;
  logic [31:0]       mag_e, mag_dy, mag_dx;
  logic              neg, zero_w;
  logic signed [31:0] y_base;
  logic [63:0]       num, num_step;
  logic [31:0]       rem, rem_step;
  logic [CNT_W-1:0]  cnt;

  logic signed [32:0] ex, dy, dx;
  logic [32:0]       t1, t2;
  logic              q1, q2;
  logic              q_big;
  logic signed [41:0] q_s, sum;
  pwli_out_t         fin;

  assign ex = {seg.x0[31], seg.x0} - {seg.lo.x[31], seg.lo.x};
  assign dy = {seg.hi.y[31], seg.hi.y} - {seg.lo.y[31], seg.lo.y};
  assign dx = {seg.hi.x[31], seg.hi.x} - {seg.lo.x[31], seg.lo.x};

  // two restoring steps
  always_comb begin
    t1 = {rem, num[63]};
    q1 = t1 >= {1'b0, mag_dx};
    if (q1) begin
      t1 = t1 - {1'b0, mag_dx};
    end
    t2 = {t1[31:0], num[62]};
    q2 = t2 >= {1'b0, mag_dx};
    if (q2) begin
      t2 = t2 - {1'b0, mag_dx};
    end
    rem_step = t2[31:0];
    num_step = {num[61:0], q1, q2};
  end

  always_comb begin
    q_big = (num[63:41] != '0) || (num[40] && (num[39:0] != '0));
    q_s   = {1'b0, num[40:0]};
    sum   = {{10{y_base[31]}}, y_base} + (neg ? -q_s : q_s);
    if (zero_w) begin
      fin.result_value = y_base;
      fin.status       = STATUS_ZERO_WIDTH;
    end else if (q_big) begin
      fin.result_value = neg ? RES_MIN : RES_MAX;
      fin.status       = STATUS_SATURATED;
    end else if (sum > 42'(RES_MAX)) begin
      fin.result_value = RES_MAX;
      fin.status       = STATUS_SATURATED;
    end else if (sum < 42'(RES_MIN)) begin
      fin.result_value = RES_MIN;
      fin.status       = STATUS_SATURATED;
    end else begin
      fin.result_value = sum[31:0];
      fin.status       = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    res_valid  = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start) begin
          phase_next = PH_MUL;
        end
      end
      PH_MUL: phase_next = PH_DIV;
      PH_DIV: begin
        if (cnt == CNT_LAST) begin
          phase_next = PH_FIN;
        end
      end
      PH_FIN: phase_next = PH_DONE;
      PH_DONE: begin
        res_valid = 1'b1;
        if (take) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        mag_e  <= mag33(ex);
        mag_dy <= mag33(dy);
        mag_dx <= mag33(dx);
        neg    <= (ex[32] ^ dy[32]) ^ dx[32];
        zero_w <= (dx == '0);
        y_base <= seg.lo.y;
      end
      PH_MUL: begin
        num <= 64'(mag_e) * 64'(mag_dy);
        rem <= '0;
        cnt <= '0;
      end
      PH_DIV: begin
        num <= num_step;
        rem <= rem_step;
        cnt <= cnt + 1'b1;
      end
      PH_FIN: res <= fin;
      default: ;
    endcase
  end

endmodule

[rtl/piecewise_linear_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit - breakpoint table with linear interpolation
// loads write one breakpoint, queries give one interpolated y per x0
//
// channel  direction  word        handshake
// cfg      in         cfg_data    cfg_write
// in       in         in_word     in_valid / in_stall
// out      out        out_word    out_valid / out_stall
//
// a load gives no word
// a query passes through the cell chain, then setup, one multiply, the divide,
// finish and the output register
// one item at a time; in_stall is high while a query is at work
// a stalled output word waits in its register while the next item is taken
// synchronous reset sets num_points to 2; the table is undefined until loaded
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [pwli_pkg::CFG_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pwli_pkg::pwli_in_t     in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pwli_pkg::pwli_out_t    out_word
);
  import pwli_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  pwli_state_t   state, state_next;
  logic [CW-1:0] num_points;
  logic          in_acc, load_acc, query_acc;
  logic          res_valid, res_take;
  pwli_out_t     res;
  pwli_point_t   wr_point;
  pwli_point_t   pts [MAX_POINTS];
  pwli_token_t   toks [MAX_POINTS+1];

  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_word.action == ACTION_LOAD);
  assign query_acc = in_acc && (in_word.action == ACTION_QUERY);
  assign wr_point  = '{x: in_word.x_value, y: in_word.y_value};

  always_comb begin
    toks[0]       = '0;
    toks[0].valid = query_acc;
    toks[0].x0    = in_word.x_value;
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    pwli_point_t prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = pts[k-1];
    end
    pwli_cell #(
      .MAX_POINTS(MAX_POINTS),
      .IDX(k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .wr_en(load_acc),
      .wr_slot(in_word.point_index),
      .wr_point(wr_point),
      .num_points(num_points),
      .prev_point(prev),
      .tok_in(toks[k]),
      .point(pts[k]),
      .tok_out(toks[k+1])
    );
  end

  pwli_arith u_arith (
    .clk(clk),
    .rst(rst),
    .start(toks[MAX_POINTS].valid),
    .seg(toks[MAX_POINTS]),
    .take(res_take),
    .res_valid(res_valid),
    .res(res)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  // point count, clamped to the range 2 to MAX_POINTS
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= CW'(2);
    end else if (cfg_write) begin
      if (32'(cfg_data) < 32'd2) begin
        num_points <= CW'(2);
      end else if (32'(cfg_data) > 32'(MAX_POINTS)) begin
        num_points <= CW'(MAX_POINTS);
      end else begin
        num_points <= CW'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (query_acc) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (toks[MAX_POINTS].valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

endmodule

[rtl/pwli_checker.sv]
// ----------------------------------------------------------------------------
// pwli_checker - port level checks of the interpolator
// bound to the top level, watches the channels over time
// ----------------------------------------------------------------------------
module pwli_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_write,
  input logic [pwli_pkg::CFG_W-1:0] cfg_data,
  input logic                       in_valid,
  input logic                       in_stall,
  input pwli_pkg::pwli_in_t         in_word,
  input logic                       out_valid,
  input logic                       out_stall,
  input pwli_pkg::pwli_out_t        out_word
);
  import pwli_pkg::*;

  logic in_acc;
  logic cfg_seen;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_seen = cfg_write && (cfg_data == cfg_data);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_word.action == ACTION_QUERY) && !cfg_seen |=> in_stall)
    else $error("query accepted without going busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_word.action == ACTION_LOAD) |=> !in_stall)
    else $error("load left the input stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == STATUS_SATURATED) |->
      (out_word.result_value == RES_MAX) || (out_word.result_value == RES_MIN))
    else $error("saturated word not at a range limit");

  a_word_after_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word without a query at work");

endmodule

bind piecewise_linear_interpolator_unit pwli_checker u_pwli_checker (.*);
